### hdl/dns_query_packet_builder_defines.svh
// ----------------------------------------------------------------------------
// DNS query packet builder assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_PACKET_BUILDER_DEFINES_SVH
`define DNS_QUERY_PACKET_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DQPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DQPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dqpb_pkg.sv
// ----------------------------------------------------------------------------
// DNS query packet builder package
// Types, constants and byte tables shared by the builder modules.
// ----------------------------------------------------------------------------
package dqpb_pkg;

    // One classified hostname character as it travels from front to back.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_dot;
        logic       is_last;
    } cmd_t;

    // One byte write toward the packet buffer.
    typedef struct packed {
        logic [8:0] byte_offset;
        logic [7:0] byte_value;
        logic       write_valid;
        logic       packet_done;
        logic [9:0] packet_length;
        logic       overflow_flag;
        logic       label_error;
    } res_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_QUERY_ID   = 8'd0;
    localparam logic [7:0] CFG_QUERY_TYPE = 8'd1;

    localparam logic [15:0] QUERY_ID_RESET   = 16'hDB42;
    localparam logic [7:0]  QUERY_TYPE_RESET = 8'h01;

    localparam logic [7:0] DOT_CHAR     = 8'h2E;
    localparam logic [3:0] HDR_LAST_IDX = 4'd11;
    localparam logic [3:0] TRL_LAST_IDX = 4'd4;
    localparam logic [9:0] OFFSET_MAX   = 10'd1023;
    localparam logic [9:0] MAX_LABEL    = 10'd63;
    localparam int         QUEUE_DEPTH  = 2;

    // Saturating increment of a byte position or a label count.
    function automatic logic [9:0] sat_inc(input logic [9:0] x);
        return (x == OFFSET_MAX) ? x : x + 10'd1;
    endfunction

    // Header bytes: id, flags 0x0100, one question, zero other counts.
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] qid);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = qid[15:8];
            4'd1:    b = qid[7:0];
            4'd2:    b = 8'h01;
            4'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Trailer bytes: root, question type, class IN.
    function automatic logic [7:0] trl_byte(input logic [3:0] idx, input logic [7:0] qtype);
        logic [7:0] b;
        unique case (idx)
            4'd2:    b = qtype;
            4'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/dqpb_queue.sv
// ----------------------------------------------------------------------------
// DNS query packet builder command queue
// Small register FIFO that decouples character intake from byte emission.
// ----------------------------------------------------------------------------
module dqpb_queue
    import dqpb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    cmd_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/dqpb_front.sv
// ----------------------------------------------------------------------------
// DNS query packet builder front end
// Accepts hostname characters and classifies them into queue commands.
// ----------------------------------------------------------------------------
module dqpb_front
    import dqpb_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_name_char,
    input  logic       s_name_end,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    // A transaction is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the character: label separator or label content, last or not.
    always_comb begin
        q_data.ch      = s_name_char;
        q_data.is_dot  = (s_name_char == DOT_CHAR);
        q_data.is_last = s_name_end;
    end

endmodule

### hdl/dqpb_back.sv
// ----------------------------------------------------------------------------
// DNS query packet builder back end
// Sequencer that turns queued commands into packet byte writes.
// ----------------------------------------------------------------------------
module dqpb_back
    import dqpb_pkg::*;
#(
    parameter int PACKET_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] query_id,
    input  logic [7:0]  query_type,
    input  logic        q_valid,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res
);

    localparam logic [12:0] PB_W = 13'(PACKET_BYTES);

    typedef enum logic [1:0] {
        PH_HDR,
        PH_CHAR,
        PH_LEN,
        PH_TRAIL
    } phase_t;

    phase_t     phase_reg, phase_next, eff_phase;
    cmd_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [3:0] idx_reg, idx_next;
    logic [9:0] wo_reg, wo_next;
    logic [9:0] lstart_reg, lstart_next;
    logic [9:0] lcount_reg, lcount_next;
    logic       hdr_sent_reg, hdr_sent_next;
    logic       ovf_reg, ovf_next;
    logic       long_reg, long_next;
    logic       m_valid_reg;
    res_t       m_res_reg;

    logic       emit, finish, go, out_free, load, ok;
    logic [9:0] off, char_off, lcount_inc, len_raw;
    logic [7:0] val;
    logic       done, long_flag;

    assign out_free = !m_valid_reg || m_ready;
    // A header already sent makes the header phase act as the character phase.
    assign eff_phase = (phase_reg == PH_HDR && hdr_sent_reg) ? PH_CHAR : phase_reg;

    // One step of the sequencer: at most one byte write per cycle.
    always_comb begin
        emit          = 1'b0;
        finish        = 1'b0;
        done          = 1'b0;
        off           = wo_reg;
        val           = 8'h00;
        long_flag     = long_reg;
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        wo_next       = wo_reg;
        lstart_next   = lstart_reg;
        lcount_next   = lcount_reg;
        hdr_sent_next = hdr_sent_reg;
        long_next     = long_reg;
        char_off      = (lcount_reg == '0) ? sat_inc(wo_reg) : wo_reg;
        lcount_inc    = sat_inc(lcount_reg);
        len_raw       = sat_inc(wo_reg);

        unique case (eff_phase)
            PH_HDR: begin
                emit    = 1'b1;
                val     = hdr_byte(idx_reg, query_id);
                wo_next = sat_inc(wo_reg);
                if (idx_reg == HDR_LAST_IDX) begin
                    idx_next      = '0;
                    hdr_sent_next = 1'b1;
                    phase_next    = PH_CHAR;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            PH_CHAR: begin
                if (!cur_reg.is_dot) begin
                    // Opening a label reserves the length slot.
                    if (lcount_reg == '0) begin
                        lstart_next = wo_reg;
                    end
                    emit        = 1'b1;
                    off         = char_off;
                    val         = cur_reg.ch;
                    lcount_next = lcount_inc;
                    long_next   = long_reg || (lcount_inc > MAX_LABEL);
                    long_flag   = long_next;
                    wo_next     = sat_inc(char_off);
                    if (cur_reg.is_last) begin
                        phase_next = PH_LEN;
                    end else begin
                        finish = 1'b1;
                    end
                end else if (lcount_reg != '0) begin
                    phase_next = PH_LEN;
                end else if (cur_reg.is_last) begin
                    phase_next = PH_TRAIL;
                    idx_next   = '0;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_LEN: begin
                // Close the label by filling its reserved length slot.
                emit        = 1'b1;
                off         = lstart_reg;
                val         = lcount_reg[7:0];
                lcount_next = '0;
                if (cur_reg.is_last) begin
                    phase_next = PH_TRAIL;
                    idx_next   = '0;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_TRAIL: begin
                emit    = 1'b1;
                val     = trl_byte(idx_reg, query_type);
                wo_next = sat_inc(wo_reg);
                if (idx_reg == TRL_LAST_IDX) begin
                    done   = 1'b1;
                    finish = 1'b1;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            default: begin
                finish = 1'b1;
            end
        endcase

        ok       = ({3'b000, off} < PB_W);
        ovf_next = ovf_reg || (emit && !ok);

        // The end of a packet returns all packet state to its reset value.
        if (done) begin
            wo_next       = '0;
            lstart_next   = '0;
            lcount_next   = '0;
            hdr_sent_next = 1'b0;
            ovf_next      = 1'b0;
            long_next     = 1'b0;
        end
    end

    assign go    = cur_valid_reg && (!emit || out_free);
    assign load  = q_valid && (!cur_valid_reg || (go && finish));
    assign q_pop = load;

    always_comb begin
        if (load) begin
            cur_valid_next = 1'b1;
        end else if (go && finish) begin
            cur_valid_next = 1'b0;
        end else begin
            cur_valid_next = cur_valid_reg;
        end
    end

    // Sequencer state and the registered output transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR;
            idx_reg       <= '0;
            wo_reg        <= '0;
            lstart_reg    <= '0;
            lcount_reg    <= '0;
            hdr_sent_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            long_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            if (load) begin
                cur_reg   <= q_data;
                phase_reg <= PH_HDR;
                idx_reg   <= '0;
            end else if (go) begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
            end
            if (go) begin
                wo_reg       <= wo_next;
                lstart_reg   <= lstart_next;
                lcount_reg   <= lcount_next;
                hdr_sent_reg <= hdr_sent_next;
                ovf_reg      <= ovf_next;
                long_reg     <= long_next;
            end
            if (go && emit) begin
                m_valid_reg                 <= 1'b1;
                m_res_reg.byte_offset       <= off[8:0];
                m_res_reg.byte_value        <= val;
                m_res_reg.write_valid       <= ok;
                m_res_reg.packet_done       <= done;
                m_res_reg.packet_length     <= done
                    ? (({3'b000, len_raw} > PB_W) ? PB_W[9:0] : len_raw) : 10'd0;
                m_res_reg.overflow_flag     <= ovf_reg || !ok;
                m_res_reg.label_error       <= long_flag;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

### hdl/dns_query_packet_builder.sv
// ----------------------------------------------------------------------------
// DNS query packet builder
// Encodes a dotted hostname into byte writes of a DNS query packet (type A by default).
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Content
// s_        in         s_valid / s_ready       s_name_char, s_name_end
// m_        out        m_valid / m_ready       one packet byte write with status
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The back end emits at most one byte write per cycle, none on a stall: a
// label character writes itself, a dot closing a label its length byte, a
// packet's first character twelve header bytes, its last character the open
// label's length byte and five trailer bytes. A two-entry command queue lets
// intake run on while the back end works or the output stalls. Reset is
// synchronous and active low; cfg_ready is always high, a write acts at once.
// ----------------------------------------------------------------------------
module dns_query_packet_builder
    import dqpb_pkg::*;
#(
    parameter int PACKET_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_name_char,
    input  logic        s_name_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_byte_offset,
    output logic [7:0]  m_byte_value,
    output logic        m_write_valid,
    output logic        m_packet_done,
    output logic [9:0]  m_packet_length,
    output logic        m_overflow_flag,
    output logic        m_label_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] query_id_reg;
    logic [7:0]  query_type_reg;
    logic        q_full, q_push, q_pop, q_valid;
    cmd_t        q_in, q_head;
    res_t        res;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_id_reg   <= QUERY_ID_RESET;
            query_type_reg <= QUERY_TYPE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_QUERY_ID) begin
                query_id_reg <= cfg_data;
            end else if (cfg_index == CFG_QUERY_TYPE) begin
                query_type_reg <= cfg_data[7:0];
            end
        end
    end

    // Intake and classification.
    dqpb_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_name_char (s_name_char),
        .s_name_end  (s_name_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    // Command queue between front and back.
    dqpb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Byte write sequencer.
    dqpb_back #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .query_id   (query_id_reg),
        .query_type (query_type_reg),
        .q_valid    (q_valid),
        .q_data     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (res)
    );

    assign m_byte_offset   = res.byte_offset;
    assign m_byte_value    = res.byte_value;
    assign m_write_valid   = res.write_valid;
    assign m_packet_done   = res.packet_done;
    assign m_packet_length = res.packet_length;
    assign m_overflow_flag = res.overflow_flag;
    assign m_label_error   = res.label_error;

endmodule

### hdl/dns_query_packet_builder_checker.sv
// ----------------------------------------------------------------------------
// DNS query packet builder checker
// Port-level properties of the builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dns_query_packet_builder_defines.svh"

module dns_query_packet_builder_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [8:0]  m_byte_offset,
    input logic [7:0]  m_byte_value,
    input logic        m_write_valid,
    input logic        m_packet_done,
    input logic [9:0]  m_packet_length,
    input logic        m_overflow_flag
);

    // A dropped write must show up in the overflow status of the same transaction.
    `DQPB_ASSERT_NOW(a_drop_ovf, m_valid && !m_write_valid, m_overflow_flag, "drop without ovf")

    // A finished packet holds at least the header and the trailer.
    `DQPB_ASSERT_NOW(a_done_len, m_valid && m_packet_done, m_packet_length >= 10'd17, "short packet")

    // The length is reported only on the final transaction of a packet.
    `DQPB_ASSERT_NOW(a_len_done, m_valid && !m_packet_done, m_packet_length == 10'd0, "stray length")

    // A stalled output transaction keeps its offset and value.
    `DQPB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable({m_byte_offset, m_byte_value}), "stall changed")

endmodule

bind dns_query_packet_builder dns_query_packet_builder_checker u_checker (.*);

### bench/tb_dns_query_packet_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query packet builder testbench
// Feeds dotted hostnames one character per transaction and checks every byte
// write against a local model of the encoder. Both channels idle at random,
// the receiver stalls once for a long stretch, and the registers are rewritten
// between phases.
// ----------------------------------------------------------------------------
module tb_dns_query_packet_builder;
    import dqpb_pkg::*;

    localparam int PKT_BYTES    = 512;
    localparam int DRAIN_CYCLES = 40;
    localparam int RX_HOLD      = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } name_item_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_name_char     = 8'h00;
    logic        s_name_end      = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [8:0]  m_byte_offset;
    logic [7:0]  m_byte_value;
    logic        m_write_valid;
    logic        m_packet_done;
    logic [9:0]  m_packet_length;
    logic        m_overflow_flag;
    logic        m_label_error;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index       = 8'h00;
    logic [15:0] cfg_data        = 16'h0000;

    // Hostname characters waiting to be sent, and byte writes still owed.
    name_item_t  name_chars_q[$];
    res_t        owed_writes_q[$];

    // Local copy of the registers and of the encoder state.
    logic [15:0] qid_cfg   = QUERY_ID_RESET;
    logic [7:0]  qtype_cfg = QUERY_TYPE_RESET;
    logic [9:0]  wr_off    = '0;
    logic [9:0]  lbl_start = '0;
    logic [9:0]  lbl_cnt   = '0;
    logic        hdr_done  = 1'b0;
    logic        ovf_seen  = 1'b0;
    logic        long_seen = 1'b0;

    int          fail_cnt    = 0;
    int          chars_taken = 0;
    bit          quiet       = 1'b0;
    int          tx_gap      = 0;
    int          rx_gap      = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    name_item_t  next_char;
    res_t        got_write;
    res_t        want_write;

    dns_query_packet_builder #(
        .PACKET_BYTES(PKT_BYTES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_name_char     (s_name_char),
        .s_name_end      (s_name_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_offset   (m_byte_offset),
        .m_byte_value    (m_byte_value),
        .m_write_valid   (m_write_valid),
        .m_packet_done   (m_packet_done),
        .m_packet_length (m_packet_length),
        .m_overflow_flag (m_overflow_flag),
        .m_label_error   (m_label_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock and a single reset at the start.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // Record one byte write; writes past the packet end are dropped.
    task automatic owe_byte(input logic [9:0] off, input logic [7:0] val);
        res_t r;
        logic ok;
        ok = (off < PKT_BYTES);
        if (!ok) ovf_seen = 1'b1;
        r.byte_offset   = off[8:0];
        r.byte_value    = val;
        r.write_valid   = ok;
        r.packet_done   = 1'b0;
        r.packet_length = '0;
        r.overflow_flag = ovf_seen;
        r.label_error   = long_seen;
        owed_writes_q.push_back(r);
    endtask

    task automatic step_offset();
        if (wr_off != OFFSET_MAX) wr_off = wr_off + 10'd1;
    endtask

    task automatic owe_next(input logic [7:0] val);
        owe_byte(wr_off, val);
        step_offset();
    endtask

    // Work out the writes that one hostname character causes.
    task automatic encode_char(input logic [7:0] ch, input logic last);
        res_t       r;
        logic [9:0] len;
        // The first character of a packet brings the header with it.
        if (!hdr_done) begin
            wr_off = '0;
            owe_next(qid_cfg[15:8]);
            owe_next(qid_cfg[7:0]);
            owe_next(8'h01);
            owe_next(8'h00);
            owe_next(8'h00);
            owe_next(8'h01);
            repeat (6) owe_next(8'h00);
            hdr_done = 1'b1;
        end
        // A label character; the first one reserves the length slot.
        if (ch != DOT_CHAR) begin
            if (lbl_cnt == 0) begin
                lbl_start = wr_off;
                step_offset();
            end
            if (lbl_cnt != OFFSET_MAX) lbl_cnt = lbl_cnt + 10'd1;
            if (lbl_cnt > MAX_LABEL) long_seen = 1'b1;
            owe_next(ch);
        end
        // A dot or the end closes an open label with its length byte.
        if ((ch == DOT_CHAR || last) && lbl_cnt != 0) begin
            owe_byte(lbl_start, lbl_cnt[7:0]);
            lbl_cnt = '0;
        end
        // Root byte, question type and class, then back to a fresh packet.
        if (last) begin
            owe_next(8'h00);
            owe_next(8'h00);
            owe_next(qtype_cfg);
            owe_next(8'h00);
            owe_next(8'h01);
            len = (wr_off > PKT_BYTES) ? 10'(PKT_BYTES) : wr_off;
            r = owed_writes_q.pop_back();
            r.packet_done   = 1'b1;
            r.packet_length = len;
            owed_writes_q.push_back(r);
            wr_off    = '0;
            lbl_start = '0;
            lbl_cnt   = '0;
            hdr_done  = 1'b0;
            ovf_seen  = 1'b0;
            long_seen = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------

    // Present queued characters, with short random gaps outside the quiet part.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_char(s_name_char, s_name_end);
                chars_taken++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    s_valid <= 1'b0;
                    tx_gap--;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    s_valid <= 1'b0;
                    tx_gap = $urandom_range(0, 3);
                end else if (name_chars_q.size() != 0) begin
                    next_char = name_chars_q.pop_front();
                    s_valid     <= 1'b1;
                    s_name_char <= next_char.ch;
                    s_name_end  <= next_char.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Ready with random stalls, plus one long hold so the input backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && chars_taken >= 40) begin
            m_ready <= 1'b0;
            hold_done = 1'b1;
            hold_left = RX_HOLD - 1;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap--;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            rx_gap = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic string write_str(input res_t r);
        return $sformatf("off=%0d val=%02h wv=%0b done=%0b len=%0d ovf=%0b lerr=%0b",
                         r.byte_offset, r.byte_value, r.write_valid, r.packet_done,
                         r.packet_length, r.overflow_flag, r.label_error);
    endfunction

    task automatic log_fail(input string what);
        fail_cnt++;
        if (fail_cnt <= 10) $display("%s", what);
    endtask

    // Compare each accepted write with the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_write = {m_byte_offset, m_byte_value, m_write_valid, m_packet_done,
                         m_packet_length, m_overflow_flag, m_label_error};
            if (owed_writes_q.size() == 0) begin
                log_fail({"unexpected write: ", write_str(got_write)});
            end else begin
                want_write = owed_writes_q.pop_front();
                if (got_write.byte_offset   != want_write.byte_offset   ||
                    got_write.byte_value    != want_write.byte_value    ||
                    got_write.write_valid   != want_write.write_valid   ||
                    got_write.packet_done   != want_write.packet_done   ||
                    got_write.packet_length != want_write.packet_length ||
                    got_write.overflow_flag != want_write.overflow_flag ||
                    got_write.label_error   != want_write.label_error) begin
                    log_fail({"mismatch: expected ", write_str(want_write),
                              " actual ", write_str(got_write)});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic add_char(input logic [7:0] ch, input logic last);
        name_item_t it;
        it.ch   = ch;
        it.last = last;
        name_chars_q.push_back(it);
    endtask

    // Any byte but the dot.
    function automatic logic [7:0] label_char();
        int v;
        v = $urandom_range(0, 254);
        if (v >= 46) v++;
        return 8'(v);
    endfunction

    // Mark the most recently queued character as the end of the hostname.
    task automatic mark_end();
        name_item_t it;
        it = name_chars_q.pop_back();
        it.last = 1'b1;
        name_chars_q.push_back(it);
    endtask

    // A dotted hostname; some carry stray leading, doubled or trailing dots.
    task automatic add_hostname(input int nlabels, input int maxlen);
        bit noisy;
        int n;
        noisy = ($urandom_range(0, 3) == 0);
        if (noisy && $urandom_range(0, 1) == 1) add_char(DOT_CHAR, 1'b0);
        for (int l = 0; l < nlabels; l++) begin
            n = $urandom_range(1, maxlen);
            repeat (n) add_char(label_char(), 1'b0);
            if (l != nlabels - 1 || (noisy && $urandom_range(0, 1) == 1))
                add_char(DOT_CHAR, 1'b0);
            if (noisy && $urandom_range(0, 2) == 0) add_char(DOT_CHAR, 1'b0);
        end
        mark_end();
    endtask

    // Raw bytes with dots likely among them.
    task automatic add_noise_name();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 2) == 0) add_char(DOT_CHAR, 1'b0);
            else add_char(8'($urandom_range(0, 255)), 1'b0);
        end
        mark_end();
    endtask

    // Mix of hostnames until the queue holds at least the given count.
    task automatic add_random_names(input int count);
        while (name_chars_q.size() < count) begin
            if ($urandom_range(0, 6) == 0) add_noise_name();
            else add_hostname($urandom_range(1, 4), 8);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_QUERY_ID) qid_cfg = val;
        else if (idx == CFG_QUERY_TYPE) qtype_cfg = val[7:0];
    endtask

    // Hold off until every queued character is taken and every write has come.
    task automatic wait_idle();
        do @(negedge aclk);
        while (name_chars_q.size() != 0 || s_valid || owed_writes_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        while (!aresetn) @(posedge aclk);

        // Reset registers: one-character name, stray and doubled dots, a name
        // that ends on a dot, an empty name, and the extreme byte values.
        add_char(8'h61, 1'b1);
        add_char(DOT_CHAR, 1'b0);
        add_char(8'h61, 1'b0);
        add_char(DOT_CHAR, 1'b0);
        add_char(DOT_CHAR, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(DOT_CHAR, 1'b1);
        add_char(DOT_CHAR, 1'b1);
        add_char(8'h00, 1'b1);
        wait_idle();

        // Registers at their low extremes.
        write_reg(CFG_QUERY_ID, 16'h0000);
        write_reg(CFG_QUERY_TYPE, 16'h0000);
        add_char(8'h78, 1'b0);
        add_char(DOT_CHAR, 1'b0);
        add_char(8'h79, 1'b1);
        wait_idle();

        // Registers at their high extremes.
        write_reg(CFG_QUERY_ID, 16'hFFFF);
        write_reg(CFG_QUERY_TYPE, 16'h00FF);
        add_char(8'h80, 1'b0);
        add_char(8'h7F, 1'b1);
        wait_idle();

        // Random hostnames under random register settings.
        repeat (3) begin
            write_reg(CFG_QUERY_ID, 16'($urandom_range(0, 65535)));
            write_reg(CFG_QUERY_TYPE, 16'($urandom_range(0, 65535)));
            add_random_names(30);
            wait_idle();
        end

        // A label just over the length limit, followed by an ordinary name
        // that shows the status clears for the next packet.
        write_reg(CFG_QUERY_ID, 16'($urandom_range(0, 65535)));
        repeat (64) add_char(label_char(), 1'b0);
        add_char(DOT_CHAR, 1'b0);
        add_char(label_char(), 1'b1);
        add_hostname(2, 5);
        wait_idle();

        // Closing stretch at reset values with no idling on either side.
        quiet = 1'b1;
        write_reg(CFG_QUERY_ID, QUERY_ID_RESET);
        write_reg(CFG_QUERY_TYPE, {8'h00, QUERY_TYPE_RESET});
        add_random_names(20);
        wait_idle();

        if (fail_cnt == 0) begin
            $display("tb_dns_query_packet_builder: PASS");
        end else begin
            $display("tb_dns_query_packet_builder: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("tb_dns_query_packet_builder: FAIL");
        $finish;
    end

endmodule
